// ----- design/awpd_pkg.sv -----
// Shared types and constants for the area window pixel density unit.
// No dependencies; every other design file refers to this package by scoped names.
`timescale 1ns / 1ps

package awpd_pkg;

    localparam int DEF_MAX_WIDTH  = 1024;
    localparam int DEF_MAX_WINDOW = 16;
    localparam int MAX_HEIGHT     = 1024;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 11;

    localparam int RST_IMAGE_WIDTH  = 640;
    localparam int RST_IMAGE_HEIGHT = 480;
    localparam int RST_WINDOW_SIZE  = 5;

    localparam int CHAN_W    = 8;
    localparam int S_TDATA_W = 24;
    localparam int DENSITY_W = 9;
    localparam int COORD_W   = 10;
    localparam int M_TDATA_W = 32;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 2'd0,
        REG_IMAGE_HEIGHT = 2'd1,
        REG_WINDOW_SIZE  = 2'd2
    } reg_idx_t;

    typedef struct packed {
        logic x_in;
        logic y_in;
        logic row0;
        logic col0;
        logic emit;
        logic last;
    } pos_flags_t;

endpackage

// ----- design/area_window_pixel_density_unit.sv -----
// Accepted requests are registered in the input stage; on advance, emitted results are
// registered in the output register. Throughput: one request per cycle unless m_tready
// stalls the output; column memory is read at accept and written back on advance, with a
// forwarding register for back-to-back same-column hits. Reset: synchronous, active low;
// clears control state and the row window. No clearing pass: row 0 ignores column memory.
`timescale 1ns / 1ps

module area_window_pixel_density_unit #(
    parameter int MAX_WIDTH  = awpd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_WINDOW = awpd_pkg::DEF_MAX_WINDOW
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [awpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [awpd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [awpd_pkg::S_TDATA_W-1:0]   s_tdata,   // red, green, blue
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [awpd_pkg::M_TDATA_W-1:0]   m_tdata,   // density, out_x, out_y, zero pad
    output logic                             m_tlast    // frame_end
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int TW = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
    localparam int PAD_W = awpd_pkg::M_TDATA_W - awpd_pkg::DENSITY_W - 2 * awpd_pkg::COORD_W;

    logic [AW-1:0]                   scan_addr;
    logic [CW-1:0]                   win_size;
    logic [awpd_pkg::COORD_W-1:0]    scan_x;
    logic [awpd_pkg::COORD_W-1:0]    scan_y;
    awpd_pkg::pos_flags_t            scan_flags;

    logic                            in_valid_reg, in_valid_next;
    logic                            set_reg;
    logic [AW-1:0]                   addr_reg;
    logic [awpd_pkg::COORD_W-1:0]    x_reg;
    logic [awpd_pkg::COORD_W-1:0]    y_reg;
    awpd_pkg::pos_flags_t            flags_reg;

    logic                            out_valid_reg, out_valid_next;
    logic [awpd_pkg::DENSITY_W-1:0]  density_reg;
    logic [awpd_pkg::COORD_W-1:0]    out_x_reg;
    logic [awpd_pkg::COORD_W-1:0]    out_y_reg;
    logic                            last_reg;

    logic                            accept;
    logic                            advance;
    logic                            pixel_set;
    logic [CW-1:0]                   col_count;
    logic [TW-1:0]                   total;

    awpd_scan #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_scan (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .step      (accept),
        .col_addr  (scan_addr),
        .win_size  (win_size),
        .pos_x     (scan_x),
        .pos_y     (scan_y),
        .flags     (scan_flags)
    );

    awpd_column #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_WINDOW (MAX_WINDOW)
    ) u_column (
        .aclk      (aclk),
        .rd_en     (accept),
        .rd_addr   (scan_addr),
        .advance   (advance),
        .cur_addr  (addr_reg),
        .cur_set   (set_reg),
        .cur_x_in  (flags_reg.x_in),
        .cur_row0  (flags_reg.row0),
        .win_size  (win_size),
        .col_count (col_count)
    );

    awpd_row #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_row (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .cur_col0  (flags_reg.col0),
        .col_count (col_count),
        .win_size  (win_size),
        .total     (total)
    );

    assign advance   = in_valid_reg && (!flags_reg.emit || !out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign accept    = s_tvalid && s_tready;
    assign pixel_set = (s_tdata != '0) && scan_flags.x_in && scan_flags.y_in;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance && flags_reg.emit)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            set_reg   <= pixel_set;
            addr_reg  <= scan_addr;
            x_reg     <= scan_x;
            y_reg     <= scan_y;
            flags_reg <= scan_flags;
        end
        if (advance && flags_reg.emit) begin
            density_reg <= awpd_pkg::DENSITY_W'(total);
            out_x_reg   <= x_reg;
            out_y_reg   <= y_reg;
            last_reg    <= flags_reg.last;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, out_y_reg, out_x_reg, density_reg};
    assign m_tlast  = last_reg;

endmodule

// ----- design/awpd_scan.sv -----
// Configuration registers and scan position counters.
// Depends on awpd_pkg.
`timescale 1ns / 1ps

module awpd_scan #(
    parameter int MAX_WIDTH  = awpd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_WINDOW = awpd_pkg::DEF_MAX_WINDOW
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [awpd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [awpd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             step,
    output logic [$clog2(MAX_WIDTH)-1:0]     col_addr,
    output logic [$clog2(MAX_WINDOW+1)-1:0]  win_size,
    output logic [awpd_pkg::COORD_W-1:0]     pos_x,
    output logic [awpd_pkg::COORD_W-1:0]     pos_y,
    output awpd_pkg::pos_flags_t             flags
);

    localparam int XW = $clog2(MAX_WIDTH + MAX_WINDOW);
    localparam int YW = $clog2(awpd_pkg::MAX_HEIGHT + MAX_WINDOW);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int HW = $clog2(awpd_pkg::MAX_HEIGHT + 1);
    localparam int SW = $clog2(MAX_WINDOW + 1);
    localparam int AW = $clog2(MAX_WIDTH);
    localparam int RST_W = (awpd_pkg::RST_IMAGE_WIDTH > MAX_WIDTH) ?
                           MAX_WIDTH : awpd_pkg::RST_IMAGE_WIDTH;
    localparam int RST_H = awpd_pkg::RST_IMAGE_HEIGHT;
    localparam int RST_S = (awpd_pkg::RST_WINDOW_SIZE > MAX_WINDOW) ?
                           MAX_WINDOW : awpd_pkg::RST_WINDOW_SIZE;

    logic [WW-1:0] width_reg, width_next;
    logic [HW-1:0] height_reg, height_next;
    logic [SW-1:0] size_reg, size_next;
    logic [XW-1:0] col_reg, col_next;
    logic [YW-1:0] row_reg, row_next;
    logic          cfg_hit;
    logic [SW-1:0] half;
    logic [XW-1:0] wp;
    logic [YW-1:0] hp;
    logic [XW-1:0] cur_x;
    logic [YW-1:0] cur_y;
    logic [XW-1:0] dx;
    logic [YW-1:0] dy;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        size_next   = size_reg;
        cfg_hit     = 1'b0;
        if (cfg_wr_en) begin
            unique case (awpd_pkg::reg_idx_t'(cfg_index))
                awpd_pkg::REG_IMAGE_WIDTH: begin
                    cfg_hit = 1'b1;
                    if (cfg_wdata == '0)
                        width_next = WW'(1);
                    else if (int'(cfg_wdata) > MAX_WIDTH)
                        width_next = WW'(MAX_WIDTH);
                    else
                        width_next = WW'(cfg_wdata);
                end
                awpd_pkg::REG_IMAGE_HEIGHT: begin
                    cfg_hit = 1'b1;
                    if (cfg_wdata == '0)
                        height_next = HW'(1);
                    else if (int'(cfg_wdata) > awpd_pkg::MAX_HEIGHT)
                        height_next = HW'(awpd_pkg::MAX_HEIGHT);
                    else
                        height_next = HW'(cfg_wdata);
                end
                awpd_pkg::REG_WINDOW_SIZE: begin
                    cfg_hit = 1'b1;
                    if (cfg_wdata[4:0] == '0)
                        size_next = SW'(1);
                    else if (int'(cfg_wdata[4:0]) > MAX_WINDOW)
                        size_next = SW'(MAX_WINDOW);
                    else
                        size_next = SW'(cfg_wdata[4:0]);
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        half  = size_reg >> 1;
        wp    = XW'(width_reg) + XW'(half);
        hp    = YW'(height_reg) + YW'(half);
        cur_x = col_reg;
        cur_y = row_reg;
        if (col_reg >= wp || row_reg >= hp) begin
            cur_x = '0;
            cur_y = '0;
        end
        dx = cur_x - XW'(half);
        dy = cur_y - YW'(half);

        col_next = col_reg;
        row_next = row_reg;
        if (cfg_hit) begin
            col_next = '0;
            row_next = '0;
        end else if (step) begin
            if (cur_x + XW'(1) >= wp) begin
                col_next = '0;
                row_next = (cur_y + YW'(1) >= hp) ? '0 : cur_y + YW'(1);
            end else begin
                col_next = cur_x + XW'(1);
                row_next = cur_y;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WW'(RST_W);
            height_reg <= HW'(RST_H);
            size_reg   <= SW'(RST_S);
            col_reg    <= '0;
            row_reg    <= '0;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            size_reg   <= size_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
        end
    end

    assign col_addr   = cur_x[AW-1:0];
    assign win_size   = size_reg;
    assign pos_x      = awpd_pkg::COORD_W'(dx);
    assign pos_y      = awpd_pkg::COORD_W'(dy);
    assign flags.x_in = cur_x < XW'(width_reg);
    assign flags.y_in = cur_y < YW'(height_reg);
    assign flags.row0 = cur_y == '0;
    assign flags.col0 = cur_x == '0;
    assign flags.emit = (cur_x >= XW'(half)) && (cur_y >= YW'(half));
    assign flags.last = (cur_x == wp - XW'(1)) && (cur_y == hp - YW'(1));

endmodule

// ----- design/awpd_column.sv -----
// Per-column history memory and vertical running count, with write-to-read forwarding.
// Depends on awpd_pkg.
`timescale 1ns / 1ps

module awpd_column #(
    parameter int MAX_WIDTH  = awpd_pkg::DEF_MAX_WIDTH,
    parameter int MAX_WINDOW = awpd_pkg::DEF_MAX_WINDOW
) (
    input  logic                             aclk,
    input  logic                             rd_en,
    input  logic [$clog2(MAX_WIDTH)-1:0]     rd_addr,
    input  logic                             advance,
    input  logic [$clog2(MAX_WIDTH)-1:0]     cur_addr,
    input  logic                             cur_set,
    input  logic                             cur_x_in,
    input  logic                             cur_row0,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]  win_size,
    output logic [$clog2(MAX_WINDOW+1)-1:0]  col_count
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int EW = MAX_WINDOW + CW;

    logic [EW-1:0]         mem [MAX_WIDTH];
    logic [EW-1:0]         rd_data_reg;
    logic [EW-1:0]         fwd_data_reg;
    logic                  fwd_hit_reg;
    logic [EW-1:0]         entry;
    logic [MAX_WINDOW-1:0] hist;
    logic [CW-1:0]         cnt;
    logic [MAX_WINDOW-1:0] mask;
    logic [MAX_WINDOW-1:0] hist_new;
    logic [CW-1:0]         cnt_new;
    logic                  old_bit;
    logic [IW-1:0]         top_idx;
    logic                  wr_en;

    always_comb begin
        entry = fwd_hit_reg ? fwd_data_reg : rd_data_reg;
        if (cur_row0)
            entry = '0;
        hist    = entry[MAX_WINDOW-1:0];
        cnt     = entry[EW-1:MAX_WINDOW];
        top_idx = IW'(win_size - CW'(1));
        old_bit = hist[top_idx];
        for (int i = 0; i < MAX_WINDOW; i++)
            mask[i] = (i < int'(win_size));
        hist_new = ({hist[MAX_WINDOW-2:0], cur_set}) & mask;
        cnt_new  = cnt - CW'(old_bit) + CW'(cur_set);
    end

    assign wr_en     = advance && cur_x_in;
    assign col_count = cur_x_in ? cnt_new : '0;

    always_ff @(posedge aclk) begin
        if (wr_en)
            mem[cur_addr] <= {cnt_new, hist_new};
        if (rd_en) begin
            rd_data_reg  <= mem[rd_addr];
            fwd_hit_reg  <= wr_en && (rd_addr == cur_addr);
            fwd_data_reg <= {cnt_new, hist_new};
        end
    end

endmodule

// ----- design/awpd_row.sv -----
// Horizontal running sum over the last window_size column counts of the row.
// Depends on awpd_pkg.
`timescale 1ns / 1ps

module awpd_row #(
    parameter int MAX_WINDOW = awpd_pkg::DEF_MAX_WINDOW
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    input  logic                                         advance,
    input  logic                                         cur_col0,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]              col_count,
    input  logic [$clog2(MAX_WINDOW+1)-1:0]              win_size,
    output logic [$clog2(MAX_WINDOW*MAX_WINDOW+1)-1:0]   total
);

    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int TW = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
    localparam int IW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    logic [CW-1:0] win_reg [MAX_WINDOW];
    logic [CW-1:0] win_next [MAX_WINDOW];
    logic [TW-1:0] total_reg;
    logic [TW-1:0] base;
    logic [CW-1:0] dropped;
    logic [IW-1:0] top_idx;

    always_comb begin
        top_idx = IW'(win_size - CW'(1));
        base    = cur_col0 ? '0 : total_reg;
        dropped = cur_col0 ? '0 : win_reg[top_idx];
        total   = base - TW'(dropped) + TW'(col_count);
        win_next[0] = col_count;
        for (int i = 1; i < MAX_WINDOW; i++)
            win_next[i] = cur_col0 ? '0 : win_reg[i-1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg <= '0;
            for (int i = 0; i < MAX_WINDOW; i++)
                win_reg[i] <= '0;
        end else if (advance) begin
            total_reg <= total;
            for (int i = 0; i < MAX_WINDOW; i++)
                win_reg[i] <= win_next[i];
        end
    end

endmodule
